// ===== rtl/core/npqp_pkg.sv =====
// ----------------------------------------------------------------------------
// npqp_pkg: shared types and constants for the palette quantizer
// Holds the payload structs of both channels, the register indexes, the
// depth-mode codes and the job record passed from the search to the packer.
// ----------------------------------------------------------------------------
package npqp_pkg;

  // Configuration register indexes.
  localparam logic CFG_DEPTH_MODE  = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  // Width of the configuration data bus (widest register).
  localparam int CFG_DATA_W = 13;

  // Depth-mode register codes. Any other code behaves as 1 bpp.
  localparam logic [1:0] DEPTH_8BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;
  localparam logic [1:0] DEPTH_1BPP = 2'd2;

  // Input item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Most bytes that one pixel may cause.
  localparam int MAX_RESULTS = 4;

  // Distance start value, above any real sum of three byte differences.
  localparam logic [9:0] DIST_INIT = 10'h3FF;

  // Normalized index size for the packer.
  typedef enum logic [1:0] {
    BPP_8,
    BPP_4,
    BPP_1
  } bpp_e;

  // Input item.
  typedef struct packed {
    logic       mode;
    logic [7:0] entry_index;
    logic [7:0] comp0;
    logic [7:0] comp1;
    logic [7:0] comp2;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       run_last;
    logic       row_end;
  } out_item_t;

  // One finished pixel, queued from the search to the packer.
  typedef struct packed {
    logic [7:0] idx;
    bpp_e       bpp;
    logic       row_done;
    logic [4:0] pad;
  } job_t;

  // Search side sequencer.
  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_DRAIN,
    F_PUSH
  } front_state_e;

  // Packer side sequencer.
  typedef enum logic [1:0] {
    B_IDLE,
    B_PUSH,
    B_FLUSH
  } back_state_e;

endpackage

// ===== rtl/core/npqp_fifo.sv =====
// ----------------------------------------------------------------------------
// npqp_fifo: small register queue
// First-in first-out store with full and empty flags; the head entry is
// shown combinationally while the queue is not empty.
// ----------------------------------------------------------------------------
module npqp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr;
  logic             do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage is written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/npqp_front.sv =====
// ----------------------------------------------------------------------------
// npqp_front: palette store and nearest-entry search
// Loads palette entries, walks the active entries one per cycle to find
// the least sum of absolute differences, tracks the row column and queues
// a job with the chosen index and the row padding for the packer.
// ----------------------------------------------------------------------------
module npqp_front #(
  parameter int WIDTH_MAX       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  npqp_pkg::in_item_t           in_item_i,
  output logic                         busy_o,
  input  logic [1:0]                   depth_mode_i,
  input  logic [npqp_pkg::CFG_DATA_W-1:0] image_width_i,
  output logic                         job_push_o,
  output npqp_pkg::job_t               job_data_o,
  input  logic                         job_full_i
);

  localparam int AW    = $clog2(PALETTE_ENTRIES);
  localparam int CNTW  = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
  localparam int WW    = ($clog2(WIDTH_MAX + 1) > npqp_pkg::CFG_DATA_W) ?
                         $clog2(WIDTH_MAX + 1) : npqp_pkg::CFG_DATA_W;
  localparam int LIM8  = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int LIM4  = (PALETTE_ENTRIES < 16) ? PALETTE_ENTRIES : 16;
  localparam int LIM1  = 2;

  npqp_pkg::front_state_e state_q, state_d;

  logic [23:0]     pal_mem [PALETTE_ENTRIES];
  logic [23:0]     rdata_q;
  logic [7:0]      addr_q;
  logic [7:0]      last_q;
  logic            rd_vld_q;
  logic [7:0]      rd_idx_q;
  logic [7:0]      c0_q, c1_q, c2_q;
  logic [9:0]      best_d_q;
  logic [7:0]      best_idx_q;
  logic [CNTW-1:0] col_q;
  npqp_pkg::bpp_e  bpp_q;
  logic            row_done_q;
  logic [4:0]      pad_q;

  logic            accept;
  logic            load_we;
  logic            pix_start;
  npqp_pkg::bpp_e  bpp_new;
  logic [7:0]      last_new;
  logic [WW-1:0]   img_ext;
  logic [WW-1:0]   width_eff;
  logic            row_done_new;
  logic [4:0]      pad_new;
  logic [7:0]      ad0, ad1, ad2;
  logic [9:0]      cand_dist;

  assign accept    = in_valid_i && (state_q == npqp_pkg::F_IDLE);
  assign load_we   = accept && (in_item_i.mode == npqp_pkg::MODE_LOAD) &&
                     ({1'b0, in_item_i.entry_index} < 9'(PALETTE_ENTRIES));
  assign pix_start = accept && (in_item_i.mode == npqp_pkg::MODE_PIXEL);

  // Index size and last searched entry from the depth mode.
  always_comb begin
    unique case (depth_mode_i)
      npqp_pkg::DEPTH_8BPP: begin
        bpp_new  = npqp_pkg::BPP_8;
        last_new = 8'(LIM8 - 1);
      end
      npqp_pkg::DEPTH_4BPP: begin
        bpp_new  = npqp_pkg::BPP_4;
        last_new = 8'(LIM4 - 1);
      end
      default: begin
        bpp_new  = npqp_pkg::BPP_1;
        last_new = 8'(LIM1 - 1);
      end
    endcase
  end

  // Row width clamped into range, end-of-row test and zero-index padding.
  always_comb begin
    img_ext = WW'(image_width_i);
    if (img_ext == '0) begin
      width_eff = WW'(1);
    end else if (img_ext > WW'(WIDTH_MAX)) begin
      width_eff = WW'(WIDTH_MAX);
    end else begin
      width_eff = img_ext;
    end
    row_done_new = ((WW'(col_q) + WW'(1)) >= width_eff);
    case (bpp_new)
      npqp_pkg::BPP_8: pad_new = 5'(2'(2'd0 - width_eff[1:0]));
      npqp_pkg::BPP_4: pad_new = 5'(3'(3'd0 - width_eff[2:0]));
      default:         pad_new = 5'd0 - width_eff[4:0];
    endcase
  end

  // Palette store: written by load items, read once per search cycle.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      pal_mem[in_item_i.entry_index[AW-1:0]] <=
        {in_item_i.comp2, in_item_i.comp1, in_item_i.comp0};
    end
    if (state_q == npqp_pkg::F_SEARCH) begin
      rdata_q <= pal_mem[addr_q[AW-1:0]];
    end
  end

  // Distance of the entry that came out of the store last cycle.
  always_comb begin
    ad0  = (c0_q > rdata_q[7:0])   ? c0_q - rdata_q[7:0]   : rdata_q[7:0] - c0_q;
    ad1  = (c1_q > rdata_q[15:8])  ? c1_q - rdata_q[15:8]  : rdata_q[15:8] - c1_q;
    ad2  = (c2_q > rdata_q[23:16]) ? c2_q - rdata_q[23:16] : rdata_q[23:16] - c2_q;
    cand_dist = 10'(ad0) + 10'(ad1) + 10'(ad2);
  end

  // Pixel registers and the running minimum; a tie keeps the older index.
  always_ff @(posedge clk_i) begin
    if (pix_start) begin
      c0_q       <= in_item_i.comp0;
      c1_q       <= in_item_i.comp1;
      c2_q       <= in_item_i.comp2;
      bpp_q      <= bpp_new;
      last_q     <= last_new;
      row_done_q <= row_done_new;
      pad_q      <= row_done_new ? pad_new : 5'd0;
      best_d_q   <= npqp_pkg::DIST_INIT;
      best_idx_q <= 8'd0;
      addr_q     <= 8'd0;
    end else begin
      if (state_q == npqp_pkg::F_SEARCH) begin
        addr_q <= addr_q + 8'd1;
      end
      if (rd_vld_q && (cand_dist < best_d_q)) begin
        best_d_q   <= cand_dist;
        best_idx_q <= rd_idx_q;
      end
    end
    rd_idx_q <= addr_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= npqp_pkg::F_IDLE;
      rd_vld_q <= 1'b0;
      col_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == npqp_pkg::F_SEARCH);
      if (pix_start) begin
        col_q <= row_done_new ? '0 : CNTW'(WW'(col_q) + WW'(1));
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npqp_pkg::F_IDLE: begin
        if (pix_start) begin
          state_d = npqp_pkg::F_SEARCH;
        end
      end
      npqp_pkg::F_SEARCH: begin
        if (addr_q == last_q) begin
          state_d = npqp_pkg::F_DRAIN;
        end
      end
      npqp_pkg::F_DRAIN: begin
        state_d = npqp_pkg::F_PUSH;
      end
      npqp_pkg::F_PUSH: begin
        if (!job_full_i) begin
          state_d = npqp_pkg::F_IDLE;
        end
      end
      default: state_d = npqp_pkg::F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o              = (state_q != npqp_pkg::F_IDLE);
    job_push_o          = (state_q == npqp_pkg::F_PUSH) && !job_full_i;
    job_data_o.idx      = best_idx_q;
    job_data_o.bpp      = bpp_q;
    job_data_o.row_done = row_done_q;
    job_data_o.pad      = pad_q;
  end

  // A finished search has always taken a real entry as its best.
  a_job_has_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> (best_d_q <= 10'd765))
    else $error("job queued without a completed search");

  // The read pipeline never runs past the last active entry.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (rd_idx_q <= last_q))
    else $error("palette read beyond the active entries");

endmodule

// ===== rtl/core/npqp_back.sv =====
// ----------------------------------------------------------------------------
// npqp_back: index packer
// Takes one job at a time, shifts its index and any row padding into the
// byte being assembled, one index per cycle unless the result queue is full,
// and queues finished bytes with last-byte and row-end flags on the last.
// ----------------------------------------------------------------------------
module npqp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_empty_i,
  input  npqp_pkg::job_t        job_data_i,
  output logic                  job_pop_o,
  input  logic                  out_full_i,
  output logic                  out_we_o,
  output npqp_pkg::out_item_t   out_data_o
);

  npqp_pkg::back_state_e state_q, state_d;

  logic [7:0]     shift_q;
  logic [2:0]     count_q;
  logic [2:0]     n_q;
  logic [7:0]     held_q;
  logic [7:0]     cur_idx_q;
  logic [4:0]     remain_q;
  npqp_pkg::bpp_e bpp_q;
  logic           row_done_q;

  logic [7:0]     shift_new;
  logic [3:0]     per_byte;
  logic           emit;
  logic           do_push;
  logic           room;
  logic           flush_done;

  // One index shifted into the byte being assembled.
  always_comb begin
    case (bpp_q)
      npqp_pkg::BPP_8: begin
        shift_new = cur_idx_q;
        per_byte  = 4'd1;
      end
      npqp_pkg::BPP_4: begin
        shift_new = {shift_q[3:0], cur_idx_q[3:0]};
        per_byte  = 4'd2;
      end
      default: begin
        shift_new = {shift_q[6:0], cur_idx_q[0]};
        per_byte  = 4'd8;
      end
    endcase
    emit = ((4'(count_q) + 4'd1) >= per_byte);
  end

  assign do_push    = (state_q == npqp_pkg::B_PUSH) && !out_full_i;
  assign room       = (n_q < 3'(npqp_pkg::MAX_RESULTS));
  assign flush_done = (state_q == npqp_pkg::B_FLUSH) && ((n_q == 3'd0) || !out_full_i);

  // Job fields, held byte and remaining padding.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_idx_q  <= job_data_i.idx;
      remain_q   <= job_data_i.pad;
      bpp_q      <= job_data_i.bpp;
      row_done_q <= job_data_i.row_done;
    end else if (do_push) begin
      cur_idx_q <= 8'd0;
      if (remain_q != 5'd0) begin
        remain_q <= remain_q - 5'd1;
      end
      if (emit && room) begin
        held_q <= shift_new;
      end
    end
  end

  // Packing state and the count of bytes of this job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npqp_pkg::B_IDLE;
      shift_q <= 8'd0;
      count_q <= 3'd0;
      n_q     <= 3'd0;
    end else begin
      state_q <= state_d;
      if (job_pop_o || flush_done) begin
        n_q <= 3'd0;
      end else if (do_push && emit && room) begin
        n_q <= n_q + 3'd1;
      end
      if (do_push) begin
        if (emit) begin
          shift_q <= 8'd0;
          count_q <= 3'd0;
        end else begin
          shift_q <= shift_new;
          count_q <= count_q + 3'd1;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npqp_pkg::B_IDLE: begin
        if (!job_empty_i) begin
          state_d = npqp_pkg::B_PUSH;
        end
      end
      npqp_pkg::B_PUSH: begin
        if (do_push && (remain_q == 5'd0)) begin
          state_d = npqp_pkg::B_FLUSH;
        end
      end
      npqp_pkg::B_FLUSH: begin
        if (flush_done) begin
          state_d = npqp_pkg::B_IDLE;
        end
      end
      default: state_d = npqp_pkg::B_IDLE;
    endcase
  end

  // Outputs: a held byte goes out when a newer one replaces it, or at the
  // end of the job with its flags.
  always_comb begin
    job_pop_o              = (state_q == npqp_pkg::B_IDLE) && !job_empty_i;
    out_data_o.packed_byte = held_q;
    out_data_o.run_last    = 1'b0;
    out_data_o.row_end     = 1'b0;
    out_we_o               = do_push && emit && room && (n_q != 3'd0);
    if ((state_q == npqp_pkg::B_FLUSH) && (n_q != 3'd0) && !out_full_i) begin
      out_we_o            = 1'b1;
      out_data_o.run_last = 1'b1;
      out_data_o.row_end  = row_done_q;
    end
  end

  // Results are only written into a queue with room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_we_o |-> !out_full_i)
    else $error("result written into a full queue");

  // The row-end byte is always the last byte of its pixel.
  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_we_o && out_data_o.row_end) |-> out_data_o.run_last)
    else $error("row end raised on a byte that is not the last one");

  // No pixel holds more bytes than the result limit.
  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 3'(npqp_pkg::MAX_RESULTS))
    else $error("byte count of a pixel above its limit");

endmodule

// ===== rtl/core/nearest_palette_quantize_pack.sv =====
// Palette load items are taken while the search is idle. A pixel occupies the
// search while it reads the active entries (up to 256 at 8 bpp, 16 at 4 bpp,
// 2 at 1 bpp) one at a time through the single read port of the palette store.
// The packer pushes one index at a time while the result queue has room,
// and overlaps the next search through the job queue.
// Reset is asynchronous and active low; the palette holds no value until loaded.
// ----------------------------------------------------------------------------
// nearest_palette_quantize_pack: palette quantizer with packed row output
// Matches each pixel to its nearest palette entry, packs the indices into
// bytes at 8, 4 or 1 bpp and pads each row to a multiple of four bytes.
// ----------------------------------------------------------------------------
module nearest_palette_quantize_pack #(
  parameter int WIDTH_MAX       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  npqp_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output npqp_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [npqp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  logic [1:0]                     depth_mode_q;
  logic [npqp_pkg::CFG_DATA_W-1:0] image_width_q;

  logic                 busy;
  logic                 job_push;
  logic                 job_pop;
  logic                 job_full;
  logic                 job_empty;
  npqp_pkg::job_t       job_wdata;
  npqp_pkg::job_t       job_rdata;
  logic                 out_we;
  logic                 out_full;
  npqp_pkg::out_item_t  out_wdata;

  assign full = busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q  <= npqp_pkg::DEPTH_8BPP;
      image_width_q <= npqp_pkg::CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        npqp_pkg::CFG_DEPTH_MODE:  depth_mode_q  <= cfg_data_i[1:0];
        npqp_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Search side.
  npqp_front #(
    .WIDTH_MAX       (WIDTH_MAX),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (push),
    .in_item_i     (in_item_i),
    .busy_o        (busy),
    .depth_mode_i  (depth_mode_q),
    .image_width_i (image_width_q),
    .job_push_o    (job_push),
    .job_data_o    (job_wdata),
    .job_full_i    (job_full)
  );

  // Job queue between search and packer.
  npqp_fifo #(
    .WIDTH ($bits(npqp_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i (job_wdata),
    .rd_en_i   (job_pop),
    .rd_data_o (job_rdata),
    .full_o    (job_full),
    .empty_o   (job_empty)
  );

  // Packer side.
  npqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_data_i  (job_rdata),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_we_o    (out_we),
    .out_data_o  (out_wdata)
  );

  // Result queue toward the consumer.
  npqp_fifo #(
    .WIDTH ($bits(npqp_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_we),
    .wr_data_i (out_wdata),
    .rd_en_i   (pop),
    .rd_data_o (out_item_o),
    .full_o    (out_full),
    .empty_o   (empty)
  );

endmodule
